// File: design/mast_pkg.sv
package mast_pkg;

   localparam int ANGLE_W        = 16;
   localparam int TIMER_W        = 16;
   localparam int POS_W          = 40;
   localparam int SPEED_W        = 32;
   localparam int TURN_BITS_DEF  = 24;
   localparam int TIMER_BITS_DEF = 16;

   localparam int PP_W   = 6;
   localparam int EOFF_W = 16;
   localparam int MOFF_W = 32;
   localparam int THR_W  = 16;
   localparam int GEAR_W = 10;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [PP_W-1:0]   PP_RST   = PP_W'(7);
   localparam logic [THR_W-1:0]  THR_RST  = THR_W'(32768);
   localparam logic [GEAR_W-1:0] GEAR_RST = GEAR_W'(1);

   // counts per microsecond to 1/16 RPM: 60e6 * 16 / 65536 = 234375 / 16
   localparam int                SCALE_W     = 18;
   localparam logic [SCALE_W-1:0] SPEED_SCALE = SCALE_W'(234375);
   localparam int                SCALE_SHIFT = 4;
   localparam int                PROD_W      = POS_W + SCALE_W;

   localparam logic [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
   localparam logic [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POLE_PAIRS  = 3'd0,
      CSR_DIR_REV     = 3'd1,
      CSR_ELEC_OFFSET = 3'd2,
      CSR_MECH_OFFSET = 3'd3,
      CSR_WRAP_THR    = 3'd4,
      CSR_GEAR_RATIO  = 3'd5
   } csr_idx_type;

endpackage

// File: design/mast_intf.sv
interface mast_req_if import mast_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ANGLE_W-1:0] raw_angle;
   logic [TIMER_W-1:0] timer_now;

   modport source (output valid, output raw_angle, output timer_now, input ready);
   modport sink (input valid, input raw_angle, input timer_now, output ready);
endinterface

interface mast_rsp_if import mast_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic        [ANGLE_W-1:0] electrical_angle;
   logic signed [POS_W-1:0]   position;
   logic signed [POS_W-1:0]   joint_position;
   logic signed [SPEED_W-1:0] speed;

   modport source (output valid, output electrical_angle, output position,
                   output joint_position, output speed, input ready);
   modport sink (input valid, input electrical_angle, input position,
                 input joint_position, input speed, output ready);
endinterface

// File: design/mast_div.sv
module mast_div import mast_pkg::*; #(
   parameter int HI_W   = 1,
   parameter int QUO_W  = POS_W,
   parameter int DSOR_W = GEAR_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [HI_W+QUO_W-1:0]   dividend,
   input  logic [DSOR_W-1:0]       divisor,
   output logic                    busy,
   output logic                    ovf,
   output logic [QUO_W-1:0]        quotient
);

   localparam int CNT_W = $clog2(QUO_W + 1);
   localparam int CMP_W = (HI_W > DSOR_W) ? HI_W : DSOR_W;

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DSOR_W-1:0] rem_ff, rem_in;
   logic [DSOR_W-1:0] dsor_ff, dsor_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic              ovf_ff, ovf_in;
   logic [HI_W-1:0]   hi;
   logic [DSOR_W+1:0] trial;
   logic              borrow;

   always_comb begin
      hi      = dividend[HI_W+QUO_W-1:QUO_W];
      trial   = {1'b0, rem_ff, quo_ff[QUO_W-1]} - {2'b00, dsor_ff};
      borrow  = trial[DSOR_W+1];
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsor_in = dsor_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      if (start) begin
         cnt_in  = CNT_W'(QUO_W);
         rem_in  = DSOR_W'(hi);
         quo_in  = dividend[QUO_W-1:0];
         dsor_in = divisor;
         ovf_in  = CMP_W'(hi) >= CMP_W'(divisor);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         rem_in = borrow ? {rem_ff[DSOR_W-2:0], quo_ff[QUO_W-1]} : trial[DSOR_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], !borrow};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsor_ff <= dsor_in;
      quo_ff  <= quo_in;
      ovf_ff  <= ovf_in;
   end

   assign busy     = (cnt_ff != '0);
   assign ovf      = ovf_ff;
   assign quotient = quo_ff;

endmodule

// File: design/mast_scale.sv
module mast_scale import mast_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [POS_W-1:0]  mag,
   output logic              busy,
   output logic [PROD_W-1:0] product
);

   localparam int CNT_W = $clog2(SCALE_W + 1);
   localparam int IDX_W = $clog2(SCALE_W);

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [POS_W-1:0]  mag_ff, mag_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [IDX_W-1:0]  idx;

   always_comb begin
      idx    = IDX_W'(cnt_ff - 1'b1);
      cnt_in = cnt_ff;
      mag_in = mag_ff;
      acc_in = acc_ff;
      if (start) begin
         cnt_in = CNT_W'(SCALE_W);
         mag_in = mag;
         acc_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         acc_in = {acc_ff[PROD_W-2:0], 1'b0}
                  + (SPEED_SCALE[idx] ? PROD_W'(mag_ff) : PROD_W'(0));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      acc_ff <= acc_in;
   end

   assign busy    = (cnt_ff != '0);
   assign product = acc_ff;

endmodule

// File: design/mast_elec.sv
module mast_elec import mast_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [ANGLE_W-1:0] raw,
   input  logic [PP_W-1:0]    pair_mult,
   input  logic               reversed,
   input  logic [EOFF_W-1:0]  offset,
   output logic               busy,
   output logic [ANGLE_W-1:0] angle
);

   localparam int CNT_W = $clog2(PP_W + 1);
   localparam int IDX_W = $clog2(PP_W);

   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ANGLE_W-1:0] raw_ff, raw_in;
   logic [ANGLE_W-1:0] acc_ff, acc_in;
   logic [IDX_W-1:0]   idx;
   logic [ANGLE_W-1:0] dir_acc;

   always_comb begin
      idx    = IDX_W'(cnt_ff - 1'b1);
      cnt_in = cnt_ff;
      raw_in = raw_ff;
      acc_in = acc_ff;
      if (start) begin
         cnt_in = CNT_W'(PP_W);
         raw_in = raw;
         acc_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         acc_in = {acc_ff[ANGLE_W-2:0], 1'b0} + (pair_mult[idx] ? raw_ff : ANGLE_W'(0));
      end
      dir_acc = reversed ? (ANGLE_W'(0) - acc_ff) : acc_ff;
      angle   = dir_acc - offset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff <= raw_in;
      acc_ff <= acc_in;
   end

   assign busy = (cnt_ff != '0);

endmodule

// File: design/multiturn_angle_speed_tracker_core.sv
// Items are handled one at a time: the input is ready only while idle, and a result
// waits for the output register to free up before the next item is taken. The 18-step
// serial constant multiply and the 32-step serial speed division run back to back,
// with the 40-step joint division and the 6-step angle multiply beside them.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active high) loads register defaults and clears turn, timer history.
module multiturn_angle_speed_tracker_core import mast_pkg::*; #(
   parameter int TURN_BITS  = TURN_BITS_DEF,
   parameter int TIMER_BITS = TIMER_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   mast_req_if.sink              req_ch,
   mast_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DSOR_W = TIMER_BITS + SCALE_SHIFT;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_TURN   = 8'b0000_0010,
      S_POS    = 8'b0000_0100,
      S_DIFF   = 8'b0000_1000,
      S_MSTART = 8'b0001_0000,
      S_MUL    = 8'b0010_0000,
      S_DIV    = 8'b0100_0000,
      S_OUT    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [PP_W-1:0]   pp_ff, pp_in;
   logic              rev_ff, rev_in;
   logic [EOFF_W-1:0] eoff_ff, eoff_in;
   logic [MOFF_W-1:0] moff_ff, moff_in;
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [GEAR_W-1:0] gear_ff, gear_in;

   logic [ANGLE_W-1:0]    prev_raw_ff, prev_raw_in;
   logic [TURN_BITS-1:0]  turn_ff, turn_in;
   logic [POS_W-1:0]      prev_pos_ff, prev_pos_in;
   logic [TIMER_BITS-1:0] prev_timer_ff, prev_timer_in;

   logic [ANGLE_W-1:0]    raw_ff, raw_in;
   logic [TIMER_BITS-1:0] tnow_ff, tnow_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [POS_W:0]        dpos_ff, dpos_in;
   logic [DSOR_W-1:0]     dsor_ff, dsor_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_W-1:0]  ea_ff, ea_in;
   logic [POS_W-1:0]    opos_ff, opos_in;
   logic [POS_W-1:0]    jpos_ff, jpos_in;
   logic [SPEED_W-1:0]  speed_ff, speed_in;

   logic                  accept;
   logic                  load_out;
   logic [ANGLE_W:0]      jump;
   logic [ANGLE_W:0]      jump_mag;
   logic [POS_W-1:0]      turns_ext;
   logic [POS_W-1:0]      moff_ext;
   logic [TIMER_BITS-1:0] dt;
   logic [POS_W-1:0]      pos_mag;
   logic [POS_W:0]        dpos_abs;
   logic [GEAR_W-1:0]     gear_eff;
   logic [SPEED_W-1:0]    speed_val;

   logic                  elec_start, elec_busy;
   logic [ANGLE_W-1:0]    elec_angle;
   logic                  jnt_start, jnt_busy, jnt_ovf;
   logic [POS_W-1:0]      jnt_q;
   logic                  scale_start, scale_busy;
   logic [PROD_W-1:0]     scale_prod;
   logic                  spd_start, spd_busy, spd_ovf;
   logic [SPEED_W-1:0]    spd_q;

   assign accept        = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = (state_ff == S_IDLE);
   assign load_out      = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      pp_in   = pp_ff;
      rev_in  = rev_ff;
      eoff_in = eoff_ff;
      moff_in = moff_ff;
      thr_in  = thr_ff;
      gear_in = gear_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_POLE_PAIRS:  pp_in   = csr_wdata[PP_W-1:0];
            CSR_DIR_REV:     rev_in  = csr_wdata[0];
            CSR_ELEC_OFFSET: eoff_in = csr_wdata[EOFF_W-1:0];
            CSR_MECH_OFFSET: moff_in = csr_wdata[MOFF_W-1:0];
            CSR_WRAP_THR:    thr_in  = csr_wdata[THR_W-1:0];
            CSR_GEAR_RATIO:  gear_in = csr_wdata[GEAR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      jump      = {1'b0, raw_ff} - {1'b0, prev_raw_ff};
      jump_mag  = jump[ANGLE_W] ? ((ANGLE_W+1)'(0) - jump) : jump;
      turns_ext = {{(POS_W-TURN_BITS){turn_ff[TURN_BITS-1]}}, turn_ff};
      moff_ext  = {{(POS_W-MOFF_W){moff_ff[MOFF_W-1]}}, moff_ff};
      dt        = tnow_ff - prev_timer_ff;
      pos_mag   = pos_ff[POS_W-1] ? (POS_W'(0) - pos_ff) : pos_ff;
      dpos_abs  = dpos_ff[POS_W] ? ((POS_W+1)'(0) - dpos_ff) : dpos_ff;
      gear_eff  = (gear_ff == '0) ? GEAR_W'(1) : gear_ff;
      if (spd_ovf || spd_q[SPEED_W-1]) begin
         speed_val = dpos_ff[POS_W] ? SPEED_MIN : SPEED_MAX;
      end else begin
         speed_val = dpos_ff[POS_W] ? (SPEED_W'(0) - spd_q) : spd_q;
      end
   end

   always_comb begin
      state_in      = state_ff;
      prev_raw_in   = prev_raw_ff;
      turn_in       = turn_ff;
      prev_pos_in   = prev_pos_ff;
      prev_timer_in = prev_timer_ff;
      raw_in        = raw_ff;
      tnow_in       = tnow_ff;
      pos_in        = pos_ff;
      dpos_in       = dpos_ff;
      dsor_in       = dsor_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      ea_in         = ea_ff;
      opos_in       = opos_ff;
      jpos_in       = jpos_ff;
      speed_in      = speed_ff;
      elec_start    = 1'b0;
      jnt_start     = 1'b0;
      scale_start   = 1'b0;
      spd_start     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               raw_in   = req_ch.raw_angle;
               tnow_in  = TIMER_BITS'(req_ch.timer_now);
               state_in = S_TURN;
            end
         end
         S_TURN: begin
            if (jump_mag > {1'b0, thr_ff}) begin
               turn_in = jump[ANGLE_W] ? (turn_ff + 1'b1) : (turn_ff - 1'b1);
            end
            prev_raw_in = raw_ff;
            state_in    = S_POS;
         end
         S_POS: begin
            pos_in        = {turns_ext[POS_W-ANGLE_W-1:0], raw_ff} - moff_ext;
            dsor_in       = {((dt == '0) ? TIMER_BITS'(1) : dt), SCALE_SHIFT'(0)};
            prev_timer_in = tnow_ff;
            state_in      = S_DIFF;
         end
         S_DIFF: begin
            dpos_in     = {pos_ff[POS_W-1], pos_ff} - {prev_pos_ff[POS_W-1], prev_pos_ff};
            prev_pos_in = pos_ff;
            elec_start  = 1'b1;
            jnt_start   = 1'b1;
            state_in    = S_MSTART;
         end
         S_MSTART: begin
            scale_start = 1'b1;
            state_in    = S_MUL;
         end
         S_MUL: begin
            if (!scale_busy) begin
               spd_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (!spd_busy && !jnt_busy && !elec_busy) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (load_out) begin
               rsp_valid_in = 1'b1;
               ea_in        = elec_angle;
               opos_in      = pos_ff;
               jpos_in      = pos_ff[POS_W-1] ? (POS_W'(0) - jnt_q) : jnt_q;
               speed_in     = speed_val;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pp_ff         <= PP_RST;
         rev_ff        <= 1'b0;
         eoff_ff       <= '0;
         moff_ff       <= '0;
         thr_ff        <= THR_RST;
         gear_ff       <= GEAR_RST;
         prev_raw_ff   <= '0;
         turn_ff       <= '0;
         prev_pos_ff   <= '0;
         prev_timer_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pp_ff         <= pp_in;
         rev_ff        <= rev_in;
         eoff_ff       <= eoff_in;
         moff_ff       <= moff_in;
         thr_ff        <= thr_in;
         gear_ff       <= gear_in;
         prev_raw_ff   <= prev_raw_in;
         turn_ff       <= turn_in;
         prev_pos_ff   <= prev_pos_in;
         prev_timer_ff <= prev_timer_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff   <= raw_in;
      tnow_ff  <= tnow_in;
      pos_ff   <= pos_in;
      dpos_ff  <= dpos_in;
      dsor_ff  <= dsor_in;
      ea_ff    <= ea_in;
      opos_ff  <= opos_in;
      jpos_ff  <= jpos_in;
      speed_ff <= speed_in;
   end

   mast_elec u_elec (
      .clock      (clock),
      .reset      (reset),
      .start      (elec_start),
      .raw        (raw_ff),
      .pair_mult  (pp_ff),
      .reversed   (rev_ff),
      .offset     (eoff_ff),
      .busy       (elec_busy),
      .angle      (elec_angle)
   );

   mast_div #(
      .HI_W   (1),
      .QUO_W  (POS_W),
      .DSOR_W (GEAR_W)
   ) u_jnt_div (
      .clock    (clock),
      .reset    (reset),
      .start    (jnt_start),
      .dividend ({1'b0, pos_mag}),
      .divisor  (gear_eff),
      .busy     (jnt_busy),
      .ovf      (jnt_ovf),
      .quotient (jnt_q)
   );

   mast_scale u_scale (
      .clock   (clock),
      .reset   (reset),
      .start   (scale_start),
      .mag     (dpos_abs[POS_W-1:0]),
      .busy    (scale_busy),
      .product (scale_prod)
   );

   mast_div #(
      .HI_W   (PROD_W - SPEED_W),
      .QUO_W  (SPEED_W),
      .DSOR_W (DSOR_W)
   ) u_spd_div (
      .clock    (clock),
      .reset    (reset),
      .start    (spd_start),
      .dividend (scale_prod),
      .divisor  (dsor_ff),
      .busy     (spd_busy),
      .ovf      (spd_ovf),
      .quotient (spd_q)
   );

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.electrical_angle = ea_ff;
   assign rsp_ch.position         = opos_ff;
   assign rsp_ch.joint_position   = jpos_ff;
   assign rsp_ch.speed            = speed_ff;

`ifndef SYNTH
   a_idle_units_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !(spd_busy || jnt_busy || scale_busy || elec_busy))
      else $error("arithmetic unit busy while idle");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) && !rsp_valid_ff |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("result not loaded into free output register");

   a_turn_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (turn_ff == $past(turn_ff)) || (turn_ff == $past(turn_ff) + 1'b1)
               || (turn_ff == $past(turn_ff) - 1'b1))
      else $error("turn count moved by more than one");

   a_joint_no_ovf: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |-> !jnt_ovf)
      else $error("joint division overflow");
`endif

endmodule

// File: bench/multiturn_angle_speed_tracker_core_tb.sv
`timescale 1ns / 1ps

module multiturn_angle_speed_tracker_core_tb;
   import mast_pkg::*;

   typedef struct {
      logic [ANGLE_W-1:0] raw;
      logic [TIMER_W-1:0] tnow;
   } encoder_sample_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] elec;
      logic [POS_W-1:0]   pos;
      logic [POS_W-1:0]   jpos;
      logic [SPEED_W-1:0] spd;
   } tracker_result_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   csr_idx_type           csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   mast_req_if req_ch ();
   mast_rsp_if rsp_ch ();

   multiturn_angle_speed_tracker_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register copies
   logic [PP_W-1:0]   pp_cfg;
   logic              rev_cfg;
   logic [EOFF_W-1:0] eoff_cfg;
   logic [MOFF_W-1:0] moff_cfg;
   logic [THR_W-1:0]  thr_cfg;
   logic [GEAR_W-1:0] gear_cfg;

   // tracker state
   logic [ANGLE_W-1:0]       last_raw = '0;
   logic [TURN_BITS_DEF-1:0] turn_cnt = '0;
   logic [POS_W-1:0]         last_pos = '0;
   logic [TIMER_W-1:0]       last_stamp = '0;

   encoder_sample_type pending_samples[$];
   tracker_result_type expected_results[$];
   encoder_sample_type next_sample;
   tracker_result_type want;

   logic               req_fire;
   logic [ANGLE_W-1:0] shaft_angle = '0;
   logic [TIMER_W-1:0] stamp = '0;
   int idle_odds;
   int gap_left = 0;
   int stall_left = 0;
   int queued_count = 0;
   int accepted_count = 0;
   int result_count = 0;
   int mismatch_count = 0;
   int settings_count = 0;
   int turn_events = 0;
   int saturations = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #12_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic tracker_result_type track_sample(input logic [ANGLE_W-1:0] raw,
                                                       input logic [TIMER_W-1:0] tnow);
      tracker_result_type r;
      logic [ANGLE_W-1:0] ang;
      logic [TIMER_W-1:0] dt16;
      logic [POS_W-1:0]   pos_w;
      longint delta, mag, turns, offs, pos, prev, jpos, gr, dt, q;
      ang = raw * pp_cfg;
      if (rev_cfg)
         ang = -ang;
      ang = ang - eoff_cfg;

      delta = longint'(raw) - longint'(last_raw);
      mag = (delta < 0) ? -delta : delta;
      if (mag > longint'(thr_cfg)) begin
         turn_events++;
         if (delta > 0)
            turn_cnt = turn_cnt - 1'b1;
         else
            turn_cnt = turn_cnt + 1'b1;
      end
      last_raw = raw;

      turns = longint'($signed(turn_cnt));
      offs = longint'($signed(moff_cfg));
      pos_w = POS_W'(turns * 65536 + longint'(raw) - offs);
      pos = longint'($signed(pos_w));

      gr = (gear_cfg == 0) ? 1 : longint'(gear_cfg);
      jpos = pos / gr;

      dt16 = tnow - last_stamp;
      dt = longint'(dt16);
      if (dt == 0)
         dt = 1;
      prev = longint'($signed(last_pos));
      q = ((pos - prev) * 234375) / (dt * 16);
      if (q > 64'sd2147483647) begin
         q = 64'sd2147483647;
         saturations++;
      end else if (q < -64'sd2147483648) begin
         q = -64'sd2147483648;
         saturations++;
      end

      last_pos = pos_w;
      last_stamp = tnow;

      r.elec = ang;
      r.pos = pos_w;
      r.jpos = jpos[POS_W-1:0];
      r.spd = q[SPEED_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint exp_val);
      mismatch_count++;
      $display("MISMATCH @%0t result %0d %s: got %0d, expected %0d",
               $time, result_count, what, got, exp_val);
   endtask

   // sender
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            next_sample = pending_samples.pop_front();
            req_ch.valid <= 1'b1;
            req_ch.raw_angle <= next_sample.raw;
            req_ch.timer_now <= next_sample.tnow;
            if (idle_odds > 0 && $urandom_range(0, idle_odds) == 0)
               gap_left = $urandom_range(1, 4);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (idle_odds > 0 && $urandom_range(0, idle_odds) == 0)
            stall_left = $urandom_range(1, 4);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            expected_results.push_back(track_sample(req_ch.raw_angle, req_ch.timer_now));
            accepted_count++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch("transfer with nothing expected", 0, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_ch.electrical_angle !== want.elec)
                  report_mismatch("electrical_angle", longint'(rsp_ch.electrical_angle),
                                  longint'(want.elec));
               if (rsp_ch.position !== want.pos)
                  report_mismatch("position", longint'(rsp_ch.position),
                                  longint'($signed(want.pos)));
               if (rsp_ch.joint_position !== want.jpos)
                  report_mismatch("joint_position", longint'(rsp_ch.joint_position),
                                  longint'($signed(want.jpos)));
               if (rsp_ch.speed !== want.spd)
                  report_mismatch("speed", longint'(rsp_ch.speed),
                                  longint'($signed(want.spd)));
            end
            result_count++;
         end
      end
   end

   task automatic queue_sample(input logic [ANGLE_W-1:0] raw, input logic [TIMER_W-1:0] tnow);
      encoder_sample_type s;
      s.raw = raw;
      s.tnow = tnow;
      pending_samples.push_back(s);
      queued_count++;
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (accepted_count != queued_count || expected_results.size() != 0);
   endtask

   task automatic put_register(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [PP_W-1:0] pp, input logic rev,
                                 input logic [EOFF_W-1:0] eoff, input logic [MOFF_W-1:0] moff,
                                 input logic [THR_W-1:0] thr, input logic [GEAR_W-1:0] gear);
      put_register(CSR_POLE_PAIRS, CSR_DATA_W'(pp));
      put_register(CSR_DIR_REV, CSR_DATA_W'(rev));
      put_register(CSR_ELEC_OFFSET, CSR_DATA_W'(eoff));
      put_register(CSR_MECH_OFFSET, moff);
      put_register(CSR_WRAP_THR, CSR_DATA_W'(thr));
      put_register(CSR_GEAR_RATIO, CSR_DATA_W'(gear));
      csr_we <= 1'b0;
      pp_cfg = pp;
      rev_cfg = rev;
      eoff_cfg = eoff;
      moff_cfg = moff;
      thr_cfg = thr;
      gear_cfg = gear;
      settings_count++;
   endtask

   task automatic pick_settings();
      logic [PP_W-1:0]   pp;
      logic [EOFF_W-1:0] eoff;
      logic [MOFF_W-1:0] moff;
      logic [THR_W-1:0]  thr;
      logic [GEAR_W-1:0] gear;
      case ($urandom_range(0, 4))
         0: pp = '0;
         1: pp = '1;
         2: pp = PP_RST;
         default: pp = PP_W'($urandom);
      endcase
      case ($urandom_range(0, 3))
         0: eoff = '0;
         1: eoff = '1;
         default: eoff = EOFF_W'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0: moff = 32'h8000_0000;
         1: moff = 32'h7FFF_FFFF;
         2: moff = '0;
         default: moff = $urandom;
      endcase
      case ($urandom_range(0, 5))
         0: thr = '0;
         1: thr = '1;
         2: thr = THR_W'($urandom_range(0, 4096));
         3: thr = THR_RST;
         default: thr = THR_W'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0: gear = '0;
         1: gear = '1;
         2: gear = GEAR_RST;
         default: gear = GEAR_W'($urandom);
      endcase
      apply_settings(pp, 1'($urandom_range(0, 1)), eoff, moff, thr, gear);
   endtask

   // mostly steady rotation with jitter, some raw noise
   task automatic queue_motion(input int count);
      int vel;
      int span;
      vel = 0;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(0, 3))
               0: span = 64;
               1: span = 4096;
               2: span = 30000;
               default: span = 40000;
            endcase
            vel = int'($urandom_range(0, 2 * span)) - span;
         end
         if ($urandom_range(0, 3) != 0) begin
            shaft_angle = ANGLE_W'(shaft_angle + vel + $urandom_range(0, 7));
            case ($urandom_range(0, 9))
               0: ;
               1: stamp = TIMER_W'(stamp + $urandom);
               default: stamp = TIMER_W'(stamp + $urandom_range(1, 2500));
            endcase
         end else begin
            shaft_angle = ANGLE_W'($urandom);
            stamp = TIMER_W'($urandom);
         end
         queue_sample(shaft_angle, stamp);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_POLE_PAIRS;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.raw_angle = '0;
      req_ch.timer_now = '0;
      rsp_ch.ready = 1'b0;
      idle_odds = 4;
      pp_cfg = PP_RST;
      rev_cfg = 1'b0;
      eoff_cfg = '0;
      moff_cfg = '0;
      thr_cfg = THR_RST;
      gear_cfg = GEAR_RST;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // defaults: zero timer delta, jumps at and just past the threshold, timer wrap
      queue_sample(16'd0, 16'd0);
      queue_sample(16'hFFFF, 16'd1);
      queue_sample(16'd0, 16'd2);
      queue_sample(16'h8000, 16'd100);
      queue_sample(16'd0, 16'd100);
      queue_sample(16'h8001, 16'hFFFF);
      queue_sample(16'd0, 16'd0);
      queue_sample(16'd1, 16'd0);
      queue_sample(16'hFFFF, 16'hFFFF);
      queue_sample(16'd12345, 16'h8000);
      queue_sample(16'hAAAA, 16'h5555);
      queue_sample(16'h5555, 16'hAAAA);
      wait_drained();

      apply_settings('1, 1'b1, '1, 32'h8000_0000, '0, '1);
      queue_sample(16'hFFFF, 16'd1);
      queue_sample(16'd0, 16'd2);
      queue_sample(16'd1, 16'd3);
      queue_sample(16'hFFFF, 16'd3);
      queue_sample(16'h8000, 16'hFFFF);
      queue_sample(16'h7FFF, 16'd0);
      wait_drained();

      // zero pole pairs and zero gear ratio
      apply_settings('0, 1'b0, 16'd1, 32'h7FFF_FFFF, '1, '0);
      queue_sample(16'd0, 16'd0);
      queue_sample(16'hFFFF, 16'd1);
      queue_sample(16'd0, 16'hFFFF);
      queue_sample(16'h8000, 16'd0);
      queue_sample(16'd1, 16'd1);
      queue_sample(16'hFFFF, 16'd2);
      wait_drained();

      for (int phase = 0; phase < 8; phase++) begin
         pick_settings();
         case (phase)
            7: idle_odds = 0;
            2, 5: idle_odds = 0;
            default: idle_odds = $urandom_range(2, 6);
         endcase
         queue_motion(178);
         wait_drained();
      end

      repeat (64) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results never seen", 0, longint'(expected_results.size()));
      $display("%0d encoder samples in, %0d results checked, %0d register settings",
               accepted_count, result_count, settings_count);
      $display("%0d turn crossings and %0d saturated speeds predicted",
               turn_events, saturations);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
